### rtl/olar_pkg.sv
package olar_pkg;

   localparam int PIPES_DEFAULT = 4;
   localparam int QDEPTH = 2;

   localparam logic [15:0] INTERVAL_RESET = 16'd1000;
   localparam logic [3:0]  RETRIES_RESET  = 4'd10;
   localparam logic [3:0]  RETRY_FULL     = 4'hF;

   localparam logic [7:0] CMD_BIND   = 8'h87;
   localparam logic [7:0] CMD_SETUP  = 8'h80;
   localparam logic [7:0] CMD_WRITE  = 8'h81;
   localparam logic [7:0] CMD_COMMIT = 8'h82;
   localparam logic [7:0] CMD_AUDIT  = 8'h83;
   localparam logic [7:0] CMD_RESET  = 8'h86;
   localparam logic [7:0] CMD_NONE   = 8'h00;
   localparam logic [7:0] OK_STATUS  = 8'h01;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_BIND   = 3'd1;
   localparam logic [2:0] PH_SETUP  = 3'd2;
   localparam logic [2:0] PH_WRITE  = 3'd3;
   localparam logic [2:0] PH_COMMIT = 3'd4;
   localparam logic [2:0] PH_AUDIT  = 3'd5;

   localparam logic [2:0] K_TX      = 3'd0;
   localparam logic [2:0] K_ACCEPT  = 3'd1;
   localparam logic [2:0] K_REJECT  = 3'd2;
   localparam logic [2:0] K_DONE    = 3'd3;
   localparam logic [2:0] K_TIMEOUT = 3'd4;

   localparam logic [1:0] MODE_BIND  = 2'd0;
   localparam logic [1:0] MODE_REPLY = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic [1:0] OP_BIND  = 2'd0;
   localparam logic [1:0] OP_REPLY = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] REASON_FLASH = 2'd0;

   localparam logic CSR_INTERVAL = 1'b0;
   localparam logic CSR_RETRIES  = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] pipe;
      logic [1:0] reason;
      logic [7:0] cmd;
      logic [7:0] status;
      logic       fopen;
      logic       rec;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [15:0] interval;
      logic [3:0]  retries;
   } cfg_type;

   typedef struct packed {
      logic [1:0] pipe;
      logic [2:0] kind;
      logic [7:0] cmd;
      logic       same;
      logic [7:0] audit;
      logic       last;
   } result_type;

endpackage

### rtl/ota_link_ack_retry_fsm_top.sv
// Channel   Dir  Beat content
// req_      in   tuser: mode; tdata: pipe_index, request_reason, reply_command,
//                reply_status, file_open, record_available
// rsp_      out  tuser: result_kind; tdata: out_pipe, command_code, same_record,
//                audit_result; tlast: last
// csr_      in   write enable, register index, write data
//
// Front registers and classifies each beat into a two-entry queue; the back
// owns all pipe state and emits at most one result per cycle.
// The back takes one queued beat at a time; a tick visits one pipe per cycle
// while rsp_ is not stalled, and results leave from a register in the back.
// Reset clears all pipe state and loads interval 1000 and retry limit 10.
// A stalled rsp_ holds the back; req_ stays open until front and queue hold 3.
module ota_link_ack_retry_fsm_top import olar_pkg::*; #(
   parameter int Pipes = PIPES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pipe_index, request_reason, reply_command,
                                   // reply_status, file_open, record_available
   input  logic [1:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_pipe, command_code, same_record, audit_result
   output logic [2:0]  rsp_tuser,  // result_kind
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   item_type   in_item;
   item_type   q_in_item;
   item_type   q_head;
   qstat_type  q_stat;
   logic       q_push;
   logic       q_pop;
   result_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval <= INTERVAL_RESET;
         cfg_ff.retries  <= RETRIES_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_INTERVAL: cfg_ff.interval <= csr_wdata;
            CSR_RETRIES:  cfg_ff.retries  <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   assign in_item.op     = OP_TICK;
   assign in_item.pipe   = req_tdata[1:0];
   assign in_item.reason = req_tdata[3:2];
   assign in_item.cmd    = req_tdata[11:4];
   assign in_item.status = req_tdata[19:12];
   assign in_item.fopen  = req_tdata[20];
   assign in_item.rec    = req_tdata[21];

   olar_front #(.Pipes(Pipes)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_mode  (req_tuser),
      .in_item  (in_item),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_item   (q_in_item)
   );

   olar_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   olar_back #(.Pipes(Pipes)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_item    (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.audit, rsp.same, rsp.cmd, rsp.pipe};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue push while full");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue pop while empty");

   a_accept_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == K_ACCEPT || rsp_tuser == K_REJECT) |-> rsp_tlast)
      else $error("bind outcome not last");

   a_done_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_DONE |-> !rsp_tlast)
      else $error("transfer done marked last");

endmodule

### rtl/olar_front.sv
module olar_front import olar_pkg::*; #(
   parameter int Pipes = PIPES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] in_mode,
   input  item_type   in_item,
   input  qstat_type  q_stat,
   output logic       q_push,
   output item_type   q_item
);

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_ff, hold_in;
   logic     keep;
   logic     accept;

   always_comb begin
      hold_in = in_item;
      case (in_mode)
         MODE_BIND: begin
            keep = 1'b1;
            hold_in.op = OP_BIND;
         end
         MODE_REPLY: begin
            keep = int'(in_item.pipe) < Pipes;
            hold_in.op = OP_REPLY;
         end
         MODE_TICK: begin
            keep = 1'b1;
            hold_in.op = OP_TICK;
         end
         default: begin
            keep = 1'b0;
            hold_in.op = OP_TICK;
         end
      endcase
   end

   assign q_push        = hold_valid_ff && !q_stat.full;
   assign in_ready      = !hold_valid_ff || q_push;
   assign accept        = in_valid && in_ready;
   assign hold_valid_in = (hold_valid_ff && !q_push) || (accept && keep);
   assign q_item        = hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (accept && keep) begin
         hold_ff <= hold_in;
      end
   end

endmodule

### rtl/olar_queue.sv
module olar_queue import olar_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  head,
   output qstat_type stat
);

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);

   item_type         ent_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign head       = ent_ff[rd_ff];
   assign stat.full  = cnt_ff == CNT_W'(QDEPTH);
   assign stat.empty = cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ff] <= push_item;
      end
   end

endmodule

### rtl/olar_back.sv
module olar_back import olar_pkg::*; #(
   parameter int Pipes = PIPES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  item_type   q_item,
   input  qstat_type  q_stat,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   localparam int PW = (Pipes > 1) ? $clog2(Pipes) : 1;
   localparam logic [PW-1:0] LAST_PIPE = PW'(Pipes - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BIND  = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_REPLY = 3'd3;
   localparam logic [2:0] S_RST   = 3'd4;
   localparam logic [2:0] S_TICK  = 3'd5;

   logic [2:0]    state_ff, state_in;
   item_type      item_ff, item_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [2:0]    phase_ff  [Pipes];
   logic [2:0]    phase_in  [Pipes];
   logic [15:0]   wait_ff   [Pipes];
   logic [15:0]   wait_in   [Pipes];
   logic [3:0]    retry_ff  [Pipes];
   logic [3:0]    retry_in  [Pipes];
   logic [1:0]    reason_ff [Pipes];
   logic [1:0]    reason_in [Pipes];
   logic          out_valid_ff;
   result_type    out_ff;

   logic          out_free;
   logic          emit;
   result_type    res;
   logic          found;
   logic [PW-1:0] free_idx;
   logic [Pipes-1:0] tick_emit;
   logic [Pipes-1:0] tick_tmo;
   logic          later;
   logic [PW-1:0] cur;
   logic [1:0]    cur_out;
   logic [2:0]    cur_phase;
   logic          ok;

   function automatic result_type mk(input logic [1:0] pipe, input logic [2:0] kind,
                                     input logic [7:0] cmd, input logic same,
                                     input logic [7:0] audit, input logic last);
      result_type r;
      r.pipe  = pipe;
      r.kind  = kind;
      r.cmd   = cmd;
      r.same  = same;
      r.audit = audit;
      r.last  = last;
      return r;
   endfunction

   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int i = Pipes - 1; i >= 0; i--) begin
         if (phase_ff[i] == PH_IDLE) begin
            found    = 1'b1;
            free_idx = PW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < Pipes; i++) begin
         tick_tmo[i]  = retry_ff[i] > cfg.retries || retry_ff[i] == RETRY_FULL;
         tick_emit[i] = phase_ff[i] != PH_IDLE && wait_ff[i] >= cfg.interval &&
                        (tick_tmo[i] || phase_ff[i] == PH_BIND ||
                         phase_ff[i] == PH_AUDIT ||
                         (item_ff.fopen && (phase_ff[i] == PH_SETUP ||
                                            phase_ff[i] == PH_WRITE ||
                                            phase_ff[i] == PH_COMMIT)));
      end
   end

   assign cur       = (state_ff == S_TICK) ? cnt_ff : PW'(item_ff.pipe);
   assign cur_out   = 2'(cur);
   assign cur_phase = phase_ff[cur];
   assign ok        = item_ff.status == OK_STATUS;

   always_comb begin
      later = 1'b0;
      for (int i = 0; i < Pipes; i++) begin
         if (PW'(i) > cnt_ff && tick_emit[i]) begin
            later = 1'b1;
         end
      end
   end

   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      retry_in  = retry_ff;
      reason_in = reason_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      res       = '0;
      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               q_pop   = 1'b1;
               item_in = q_item;
               cnt_in  = '0;
               case (q_item.op)
                  OP_BIND:  state_in = S_BIND;
                  OP_REPLY: state_in = S_REPLY;
                  OP_TICK:  state_in = S_TICK;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_BIND: begin
            if (out_free) begin
               emit = 1'b1;
               if (!found) begin
                  res      = mk(2'd0, K_REJECT, CMD_NONE, 1'b0, 8'd0, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  phase_in[free_idx]  = PH_BIND;
                  reason_in[free_idx] = item_ff.reason;
                  wait_in[free_idx]   = '0;
                  retry_in[free_idx]  = '0;
                  res      = mk(2'(free_idx), K_TX, CMD_BIND, 1'b0, 8'd0, 1'b0);
                  cnt_in   = free_idx;
                  state_in = S_ACC;
               end
            end
         end
         S_ACC: begin
            if (out_free) begin
               emit     = 1'b1;
               res      = mk(2'(cnt_ff), K_ACCEPT, CMD_NONE, 1'b0, 8'd0, 1'b1);
               state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (cur_phase)
                  PH_BIND: begin
                     if (item_ff.cmd == CMD_BIND) begin
                        wait_in[cur]  = '0;
                        retry_in[cur] = '0;
                        if (reason_ff[cur] == REASON_FLASH) begin
                           if (!item_ff.fopen) begin
                              phase_in[cur] = PH_IDLE;
                           end else if (item_ff.rec) begin
                              phase_in[cur] = PH_SETUP;
                              emit = 1'b1;
                              res  = mk(cur_out, K_TX, CMD_SETUP, 1'b0, 8'd0, 1'b1);
                           end else begin
                              phase_in[cur] = PH_AUDIT;
                              emit = 1'b1;
                              res  = mk(cur_out, K_TX, CMD_AUDIT, 1'b0, 8'd0, 1'b1);
                           end
                        end
                     end
                  end
                  PH_SETUP: begin
                     if (item_ff.cmd == CMD_SETUP) begin
                        if (ok) begin
                           phase_in[cur] = PH_WRITE;
                           wait_in[cur]  = '0;
                           retry_in[cur] = '0;
                           emit = item_ff.fopen;
                           res  = mk(cur_out, K_TX, CMD_WRITE, 1'b0, 8'd0, 1'b1);
                        end else begin
                           emit = item_ff.fopen;
                           res  = mk(cur_out, K_TX, CMD_SETUP, 1'b1, 8'd0, 1'b1);
                        end
                     end
                  end
                  PH_WRITE: begin
                     if (item_ff.cmd == CMD_WRITE) begin
                        if (ok) begin
                           phase_in[cur] = PH_COMMIT;
                           wait_in[cur]  = '0;
                           retry_in[cur] = '0;
                           emit = item_ff.fopen;
                           res  = mk(cur_out, K_TX, CMD_COMMIT, 1'b0, 8'd0, 1'b1);
                        end else begin
                           emit = item_ff.fopen;
                           res  = mk(cur_out, K_TX, CMD_WRITE, 1'b0, 8'd0, 1'b1);
                        end
                     end
                  end
                  PH_COMMIT: begin
                     if (item_ff.cmd == CMD_COMMIT && item_ff.fopen) begin
                        emit = 1'b1;
                        if (!ok) begin
                           res = mk(cur_out, K_TX, CMD_COMMIT, 1'b0, 8'd0, 1'b1);
                        end else begin
                           wait_in[cur]  = '0;
                           retry_in[cur] = '0;
                           if (item_ff.rec) begin
                              phase_in[cur] = PH_SETUP;
                              res = mk(cur_out, K_TX, CMD_SETUP, 1'b0, 8'd0, 1'b1);
                           end else begin
                              phase_in[cur] = PH_AUDIT;
                              res = mk(cur_out, K_TX, CMD_AUDIT, 1'b0, 8'd0, 1'b1);
                           end
                        end
                     end
                  end
                  PH_AUDIT: begin
                     if (item_ff.cmd == CMD_AUDIT) begin
                        emit = 1'b1;
                        res  = mk(cur_out, K_DONE, CMD_NONE, 1'b0,
                                  {7'd0, item_ff.status != 8'd0}, 1'b0);
                        phase_in[cur] = PH_IDLE;
                        wait_in[cur]  = '0;
                        retry_in[cur] = '0;
                        state_in      = S_RST;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RST: begin
            if (out_free) begin
               emit     = 1'b1;
               res      = mk(cur_out, K_TX, CMD_RESET, 1'b0, 8'd0, 1'b1);
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (out_free) begin
               state_in = (cnt_ff == LAST_PIPE) ? S_IDLE : S_TICK;
               cnt_in   = cnt_ff + PW'(1);
               if (cur_phase != PH_IDLE) begin
                  if (wait_ff[cur] < cfg.interval) begin
                     wait_in[cur] = wait_ff[cur] + 16'd1;
                  end else if (tick_tmo[cur]) begin
                     emit = 1'b1;
                     res  = mk(cur_out, K_TIMEOUT, CMD_NONE, 1'b0, 8'd0, !later);
                     phase_in[cur] = PH_IDLE;
                     wait_in[cur]  = '0;
                     retry_in[cur] = '0;
                  end else begin
                     wait_in[cur]  = '0;
                     retry_in[cur] = retry_ff[cur] + 4'd1;
                     emit = tick_emit[cur];
                     case (cur_phase)
                        PH_BIND:
                           res = mk(cur_out, K_TX, CMD_BIND, 1'b0, 8'd0, !later);
                        PH_AUDIT:
                           res = mk(cur_out, K_TX, CMD_AUDIT, 1'b0, 8'd0, !later);
                        PH_SETUP:
                           res = mk(cur_out, K_TX, CMD_SETUP, 1'b1, 8'd0, !later);
                        PH_WRITE:
                           res = mk(cur_out, K_TX, CMD_WRITE, 1'b0, 8'd0, !later);
                        PH_COMMIT:
                           res = mk(cur_out, K_TX, CMD_COMMIT, 1'b0, 8'd0, !later);
                        default:
                           res = mk(cur_out, K_TX, CMD_NONE, 1'b0, 8'd0, !later);
                     endcase
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < Pipes; i++) begin
            phase_ff[i]  <= PH_IDLE;
            wait_ff[i]   <= '0;
            retry_ff[i]  <= '0;
            reason_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         retry_ff  <= retry_in;
         reason_ff <= reason_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      item_ff <= item_in;
      if (emit) begin
         out_ff <= res;
      end
   end

endmodule
